[design/lr_pkg.sv]
`timescale 1ns / 1ps

package lr_pkg;

   localparam int COORD_W       = 6;
   localparam int COLOR_W       = 4;
   localparam int TILE_SIZE_DEF = 64;
   // error term spans about -2*63 .. 2*63
   localparam int ERR_W         = 9;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [COLOR_W-1:0] line_color;
   } lr_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_pixel;
   } lr_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic emit;
   } lr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_end;
      logic out_free;
   } lr_stat_type;

endpackage

[design/lr_ctrl.sv]
`timescale 1ns / 1ps

module lr_ctrl import lr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lr_stat_type stat,
   output lr_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DRAW = 2'b10
   } lr_state_type;

   lr_state_type state_ff, state_in;

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd.load  = req_valid && req_ready;
      cmd.emit  = (state_ff == ST_DRAW) && stat.out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_DRAW;
         end
         ST_DRAW: begin
            if (cmd.emit && stat.at_end) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[design/lr_dp.sv]
`timescale 1ns / 1ps

module lr_dp import lr_pkg::*; #(
   parameter int TILE_SIZE = TILE_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  lr_req_type  req_payload,
   input  lr_cmd_type  cmd,
   output lr_stat_type stat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lr_rsp_type  rsp_payload
);

   localparam logic [COORD_W-1:0] MAX_C = COORD_W'(TILE_SIZE - 1);
   localparam int EXT_W = ERR_W + 1 - COORD_W;

   logic [COORD_W-1:0] cx_ff, cy_ff, ex_ff, ey_ff, dx_ff, dy_ff;
   logic [COORD_W-1:0] cx_in, cy_in, ex_in, ey_in, dx_in, dy_in;
   logic               sx_ff, sy_ff, sx_in, sy_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   lr_rsp_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [COORD_W-1:0] lx0, ly0, lx1, ly1;
   logic signed [ERR_W:0] e2, dx_s, dy_s, err_sum;
   logic                  step_x, step_y;

   function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
      clamp = (v > MAX_C) ? MAX_C : v;
   endfunction

   always_comb begin
      lx0 = clamp(req_payload.start_x);
      ly0 = clamp(req_payload.start_y);
      lx1 = clamp(req_payload.end_x);
      ly1 = clamp(req_payload.end_y);

      dx_s    = $signed({{EXT_W{1'b0}}, dx_ff});
      dy_s    = $signed({{EXT_W{1'b0}}, dy_ff});
      e2      = $signed({err_ff, 1'b0});
      step_x  = e2 > -dy_s;
      step_y  = e2 < dx_s;
      err_sum = $signed({err_ff[ERR_W-1], err_ff})
                - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);

      stat.at_end   = (cx_ff == ex_ff) && (cy_ff == ey_ff);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      color_in = color_ff;
      err_in   = err_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         cx_in    = lx0;
         cy_in    = ly0;
         ex_in    = lx1;
         ey_in    = ly1;
         dx_in    = (lx1 > lx0) ? lx1 - lx0 : lx0 - lx1;
         dy_in    = (ly1 > ly0) ? ly1 - ly0 : ly0 - ly1;
         sx_in    = lx0 < lx1;
         sy_in    = ly0 < ly1;
         color_in = req_payload.line_color;
         err_in   = $signed({{(EXT_W - 1){1'b0}}, dx_in})
                    - $signed({{(EXT_W - 1){1'b0}}, dy_in});
      end

      if (cmd.emit) begin
         rsp_in.pixel_x     = cx_ff;
         rsp_in.pixel_y     = cy_ff;
         rsp_in.pixel_color = color_ff;
         rsp_in.last_pixel  = stat.at_end;
         rsp_valid_in       = 1'b1;
         if (step_x) cx_in = sx_ff ? cx_ff + 1'b1 : cx_ff - 1'b1;
         if (step_y) cy_in = sy_ff ? cy_ff + 1'b1 : cy_ff - 1'b1;
         err_in = err_sum[ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      color_ff <= color_in;
      err_ff   <= err_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[design/line_rasterizer_top.sv]
`timescale 1ns / 1ps
// a request beat loads the stepper registers and the draw state; the first pixel
//   beat is then registered in the output register that drives rsp_valid
// a line of N = max(|dx|,|dy|)+1 pixels (up to TILE_SIZE) holds the block; the
//   stepper emits one pixel per cycle unless rsp stalls, which pauses it; the next
//   request is taken once the end point sits in the output register
// reset: synchronous, clears controller state and the output valid flag

module line_rasterizer_top import lr_pkg::*; #(
   parameter int TILE_SIZE = TILE_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request channel, one line per beat
   input  logic       req_valid,
   output logic       req_ready,
   input  lr_req_type req_payload,
   // pixel channel, one pixel per beat
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output lr_rsp_type rsp_payload
);

   // command and status between the sequencer and the stepper
   lr_cmd_type  cmd;
   lr_stat_type stat;

   // idle/draw sequencer, owns req_ready
   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // clamp, delta setup, bresenham step and output register
   lr_dp #(
      .TILE_SIZE (TILE_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[design/lr_checker.sv]
`timescale 1ns / 1ps

module lr_checker import lr_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input lr_rsp_type rsp_payload
);

   // no pixel right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel valid after reset");

   // a held pixel beat stays unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("pixel beat changed while stalled");

   // a taken request blocks the next one: req_ready is low in the following cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // no new request while a line is still mid-way
   a_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_pixel |-> !req_ready)
      else $error("request ready before line end");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (.*);
